[rtl/pagu_pkg.sv]
package pagu_pkg;

    localparam int GLYPH_ROWS = 16;
    localparam int ROW_W      = 4;

    localparam logic [1:0] OP_FONT_WRITE = 2'd0;
    localparam logic [1:0] OP_TEXT       = 2'd1;
    localparam logic [1:0] OP_GRAPHICS   = 2'd2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_ATTR_MAP     = 3'd0;
    localparam logic [2:0] REG_FONT_OPTIONS = 3'd1;
    localparam logic [2:0] REG_MODE_BITS    = 3'd2;
    localparam logic [2:0] REG_CURSOR_SHAPE = 3'd3;
    localparam logic [2:0] REG_CURSOR_END   = 3'd4;
    localparam logic [2:0] REG_CURSOR_ADDR  = 3'd5;
    localparam logic [2:0] REG_FG_COLOR     = 3'd6;

    localparam logic [3:0] ATTR_MAP_RESET = 4'd4;

    localparam int MODE_80COL  = 0;
    localparam int MODE_ENABLE = 3;
    localparam int MODE_1BPP   = 4;
    localparam int MODE_BLINK  = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [10:0] glyph_index;
        logic [3:0]  glyph_row;
        logic [7:0]  font_byte;
        logic [7:0]  char_code;
        logic [7:0]  attr_byte;
        logic [3:0]  scan_row;
        logic [14:0] cell_address;
        logic        blink_phase;
        logic        line_odd;
        logic [7:0]  graphics_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixels;
        logic        wide_result;
    } t_result;

    typedef struct packed {
        logic [3:0]  attr_map;
        logic [2:0]  font_options;
        logic [5:0]  mode_bits;
        logic [6:0]  cursor_shape_start;
        logic [3:0]  cursor_end;
        logic [14:0] cursor_address;
        logic [3:0]  fg_color;
    } t_cfg;

    // one classified render job handed from front to back
    typedef struct packed {
        logic       is_text;
        logic       wide;
        logic       fg;
        logic       bg;
        logic       cursor;
        logic       mono;
        logic       gfx_en;
        logic       gfx_fg;
        logic       line_odd;
        logic [7:0] data;
    } t_work;

endpackage

[rtl/pagu_regs.sv]
module pagu_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pagu_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pagu_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pagu_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output pagu_pkg::t_cfg                      o_cfg
);

    pagu_pkg::t_cfg r_cfg;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attr_map           <= pagu_pkg::ATTR_MAP_RESET;
            r_cfg.font_options       <= '0;
            r_cfg.mode_bits          <= '0;
            r_cfg.cursor_shape_start <= '0;
            r_cfg.cursor_end         <= '0;
            r_cfg.cursor_address     <= '0;
            r_cfg.fg_color           <= '0;
        end else if (wr_en) begin
            unique case (reg_index)
                pagu_pkg::REG_ATTR_MAP:     r_cfg.attr_map           <= pwdata[3:0];
                pagu_pkg::REG_FONT_OPTIONS: r_cfg.font_options       <= pwdata[2:0];
                pagu_pkg::REG_MODE_BITS:    r_cfg.mode_bits          <= pwdata[5:0];
                pagu_pkg::REG_CURSOR_SHAPE: r_cfg.cursor_shape_start <= pwdata[6:0];
                pagu_pkg::REG_CURSOR_END:   r_cfg.cursor_end         <= pwdata[3:0];
                pagu_pkg::REG_CURSOR_ADDR:  r_cfg.cursor_address     <= pwdata[14:0];
                pagu_pkg::REG_FG_COLOR:     r_cfg.fg_color           <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            pagu_pkg::REG_ATTR_MAP:     prdata = {28'd0, r_cfg.attr_map};
            pagu_pkg::REG_FONT_OPTIONS: prdata = {29'd0, r_cfg.font_options};
            pagu_pkg::REG_MODE_BITS:    prdata = {26'd0, r_cfg.mode_bits};
            pagu_pkg::REG_CURSOR_SHAPE: prdata = {25'd0, r_cfg.cursor_shape_start};
            pagu_pkg::REG_CURSOR_END:   prdata = {28'd0, r_cfg.cursor_end};
            pagu_pkg::REG_CURSOR_ADDR:  prdata = {17'd0, r_cfg.cursor_address};
            pagu_pkg::REG_FG_COLOR:     prdata = {28'd0, r_cfg.fg_color};
            default:                    prdata = '0;
        endcase
    end

endmodule

[rtl/pagu_front.sv]
module pagu_front #(
    parameter int GLYPH_COUNT = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pagu_pkg::t_in_item i_item,
    input  pagu_pkg::t_cfg     i_cfg,
    input  logic               i_q_full,
    output logic               o_full,
    output logic               o_q_push,
    output pagu_pkg::t_work    o_q_data
);

    localparam int GLYPH_W   = $clog2(GLYPH_COUNT);
    localparam int MEM_DEPTH = GLYPH_COUNT * pagu_pkg::GLYPH_ROWS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // glyph numbers reach at most 2047, so three subtractions cover any GLYPH_COUNT of 512 or more
    function automatic logic [GLYPH_W-1:0] wrap_glyph(input logic [10:0] g);
        logic [11:0] v;
        v = {1'b0, g};
        for (int i = 0; i < 3; i++) begin
            if (v >= 12'(GLYPH_COUNT)) begin
                v = v - 12'(GLYPH_COUNT);
            end
        end
        return v[GLYPH_W-1:0];
    endfunction

    logic [7:0]        r_font_mem [MEM_DEPTH];
    logic [7:0]        r_rd_data;
    logic              r_s1_valid;
    pagu_pkg::t_work   r_s1;
    pagu_pkg::t_work   n_s1;

    logic              accept;
    logic              is_write;
    logic              is_text;
    logic              is_render;
    logic [MEM_AW-1:0] mem_addr;

    logic [7:0]        a;
    logic [6:0]        lo;
    logic              btab;
    logic              bg;
    logic              fg;
    logic              bold;
    logic              line_on;
    logic              cursor;
    logic              blink;
    logic              bank_hi;
    logic [10:0]       glyph_sum;
    logic [4:0]        row_x2;
    logic [4:0]        start_x2;
    logic [4:0]        end_x2;

    assign o_full   = r_s1_valid && i_q_full;
    assign o_q_push = r_s1_valid && !i_q_full;
    assign accept   = i_push && !o_full;

    assign is_write  = (i_item.opcode == pagu_pkg::OP_FONT_WRITE);
    assign is_text   = (i_item.opcode == pagu_pkg::OP_TEXT);
    assign is_render = is_text || (i_item.opcode == pagu_pkg::OP_GRAPHICS);

    assign a    = i_item.attr_byte;
    assign lo   = a[6:0];
    assign btab = i_cfg.mode_bits[pagu_pkg::MODE_BLINK];

    // attribute map: later rules override earlier ones
    always_comb begin
        bold = a[3];
        bg   = 1'b1;
        fg   = 1'b0;
        if (a >= 8'h11 && a[2:0] != 3'd0) begin
            bg = i_cfg.attr_map[2];
            fg = !i_cfg.attr_map[2];
            if (i_cfg.attr_map[3]) begin
                bold = 1'b1;
            end
        end
        if (a >= 8'h01 && a <= 8'h0E && a != 8'h07) begin
            bg = i_cfg.attr_map[0];
            fg = !i_cfg.attr_map[0];
            if (i_cfg.attr_map[1]) begin
                bold = 1'b1;
            end
        end
        if (btab && a >= 8'h81 && a <= 8'h8E && a != 8'h87) begin
            bg = i_cfg.attr_map[0];
            fg = !i_cfg.attr_map[0];
        end
        if (a == 8'h07 || a == 8'h0F || (btab && (a == 8'h87 || a == 8'h8F))) begin
            bg = 1'b0;
            fg = 1'b1;
        end
        if (a >= 8'h81 && a <= 8'h8F) begin
            if (!btab) begin
                bg = 1'b0;
                fg = 1'b1;
            end
            bold = a[3];
        end
        // repeated nibble: blank cell
        if (!btab && a[7:4] == a[3:0]) begin
            bg = 1'b0;
            fg = 1'b0;
        end
        if (btab && lo <= 7'h77 && lo[3] == 1'b0 && lo[6:4] == lo[2:0]) begin
            bg = 1'b0;
            fg = 1'b0;
        end
    end

    assign row_x2   = {1'b0, i_item.scan_row};
    assign start_x2 = {i_cfg.cursor_shape_start[3:0], 1'b0};
    assign end_x2   = {i_cfg.cursor_end, 1'b0};
    assign line_on  = ((i_cfg.cursor_shape_start & 7'h60) != 7'h20)
                      && (start_x2 <= row_x2) && (end_x2 >= row_x2);
    assign cursor   = (i_item.cell_address == i_cfg.cursor_address) && line_on
                      && i_cfg.mode_bits[pagu_pkg::MODE_ENABLE] && i_item.blink_phase;
    assign blink    = i_item.blink_phase && btab && a[7] && !cursor;

    assign bank_hi   = i_cfg.font_options[2] ? bold : !bold;
    assign glyph_sum = {3'd0, i_item.char_code} + {2'd0, bank_hi, 8'd0}
                       + {i_cfg.font_options[1:0], 9'd0};

    always_comb begin
        if (is_write) begin
            mem_addr = {wrap_glyph(i_item.glyph_index), i_item.glyph_row};
        end else begin
            mem_addr = {wrap_glyph(glyph_sum), i_item.scan_row};
        end
    end

    always_comb begin
        n_s1.is_text  = is_text;
        n_s1.wide     = !i_cfg.mode_bits[pagu_pkg::MODE_80COL];
        n_s1.fg       = blink ? bg : fg;
        n_s1.bg       = bg;
        n_s1.cursor   = cursor;
        n_s1.mono     = i_cfg.mode_bits[pagu_pkg::MODE_1BPP];
        n_s1.gfx_en   = i_cfg.mode_bits[pagu_pkg::MODE_ENABLE];
        n_s1.gfx_fg   = (i_cfg.fg_color != 4'd0);
        n_s1.line_odd = i_item.line_odd;
        n_s1.data     = i_item.graphics_byte;
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_write) begin
            r_font_mem[mem_addr] <= i_item.font_byte;
        end
        if (accept && is_text) begin
            r_rd_data <= r_font_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && is_render) begin
            r_s1_valid <= 1'b1;
        end else if (o_q_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    always_comb begin
        o_q_data = r_s1;
        if (r_s1.is_text) begin
            o_q_data.data = r_rd_data;
        end
    end

endmodule

[rtl/pagu_queue.sv]
module pagu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pagu_pkg::t_work i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pagu_pkg::t_work o_data
);

    pagu_pkg::t_work               r_mem [pagu_pkg::QUEUE_DEPTH];
    logic [pagu_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [pagu_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [pagu_pkg::QPTR_W:0]     r_count;

    assign o_full  = (r_count == (pagu_pkg::QPTR_W + 1)'(pagu_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/pagu_back.sv]
module pagu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  pagu_pkg::t_work   i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output pagu_pkg::t_result o_result
);

    logic              r_out_valid;
    pagu_pkg::t_result r_out;
    pagu_pkg::t_result n_out;
    logic              load;
    logic [7:0]        text8;
    logic [15:0]       text16;
    logic [7:0]        gfx8;
    logic [1:0]        pat;

    assign load     = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop  = load;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_comb begin
        for (int c = 0; c < 8; c++) begin
            text8[c]         = (i_q_data.data[c] ? i_q_data.fg : i_q_data.bg) ^ i_q_data.cursor;
            text16[2*c]      = text8[c];
            text16[2*c + 1]  = text8[c];
        end
    end

    always_comb begin
        pat  = 2'b00;
        gfx8 = '0;
        if (i_q_data.mono) begin
            gfx8 = i_q_data.data & {8{i_q_data.gfx_en && i_q_data.gfx_fg}};
        end else begin
            for (int p = 0; p < 4; p++) begin
                pat = i_q_data.gfx_en ? i_q_data.data[2*p +: 2] : 2'b00;
                // dither the two mid greys by line parity
                unique case (pat)
                    2'b00: gfx8[2*p +: 2] = 2'b00;
                    2'b11: gfx8[2*p +: 2] = 2'b11;
                    2'b01: gfx8[2*p +: 2] = i_q_data.line_odd ? 2'b00 : 2'b10;
                    2'b10: gfx8[2*p +: 2] = i_q_data.line_odd ? 2'b01 : 2'b10;
                    default: gfx8[2*p +: 2] = 2'b00;
                endcase
            end
        end
    end

    always_comb begin
        if (i_q_data.is_text && i_q_data.wide) begin
            n_out.pixels      = text16;
            n_out.wide_result = 1'b1;
        end else if (i_q_data.is_text) begin
            n_out.pixels      = {text8, 8'd0};
            n_out.wide_result = 1'b0;
        end else begin
            n_out.pixels      = {gfx8, 8'd0};
            n_out.wide_result = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/plasma_attribute_pixel_generator_unit.sv]
// A render beat passes the front stage register, the queue and the o_result register.
// One beat per cycle while full is low; one-port font RAM, read or written per beat.
// Font writes produce no result; unused opcodes are dropped.
// Reset (i_rst_n low, synchronous) empties the pipeline and queue and loads the
// register defaults; the font RAM is not cleared and holds garbage until written.
module plasma_attribute_pixel_generator_unit #(
    parameter int GLYPH_COUNT = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  pagu_pkg::t_in_item                  i_item,
    output logic                                empty,
    input  logic                                pop,
    output pagu_pkg::t_result                   o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pagu_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pagu_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pagu_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    pagu_pkg::t_cfg  cfg;
    pagu_pkg::t_work fq_data;
    pagu_pkg::t_work qb_data;
    logic            fq_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;

    pagu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pagu_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (fq_push),
        .o_q_data (fq_data)
    );

    pagu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  (fq_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (qb_data)
    );

    pagu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (qb_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule
